@@ rtl/core/imhdk_pkg.sv @@
// Shared types and constants for the indexed min-heap priority queue.
package imhdk_pkg;

    localparam int DIST_W           = 31;
    localparam int VTX_W            = 10;
    localparam int VCNT_W           = 11;
    localparam int MAX_VERTICES_DEF = 1024;

    localparam logic [DIST_W-1:0] INF_DIST    = {DIST_W{1'b1}};
    localparam logic [VCNT_W-1:0] VCNT_RESET  = 11'd1024;

    typedef enum logic [1:0] {
        CMD_UPDATE  = 2'd0,
        CMD_POP     = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_POPPED  = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_UPDATED = 2'd2,
        ST_NOP     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_SLOT,
        S_UP_RD,
        S_UP_CMP,
        S_POP_ROOT,
        S_POP_LAST,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_RESP
    } state_t;

endpackage

@@ rtl/core/imhdk_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module imhdk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/indexed_min_heap_decrease_key.sv @@
// Indexed binary min-heap of (vertex, distance) with decrease-key, pop and restart.
//
// Heap entries and the vertex-to-slot map each sit in a single-port-read RAM;
// every step of a sift issues a RAM read and waits for its registered data.
// An update sifts up the heap level by level; a pop sifts down level by level.
// Restart, and the clearing pass after reset, sweep both RAMs one entry per
// cycle, during which no transaction is accepted.
// Empty pops, ignored updates and the unused command answer without writing either RAM.
// A result waits in the output register; the next transaction is accepted
// once the core is back in idle.
module indexed_min_heap_decrease_key
    import imhdk_pkg::*;
#(
    parameter int MAX_VERTICES = imhdk_pkg::MAX_VERTICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,   // vertex_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // [9:0] vertex, [40:10] distance, zero fill
    input  logic [1:0]  s_tuser,       // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // [9:0] popped_vertex, [40:10] popped_distance
    output logic [1:0]  m_tuser        // [1:0] status
);

    localparam int SW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int HW = SW + DIST_W;
    localparam int XW = (SW > VTX_W) ? SW : VTX_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_VERTICES - 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [VCNT_W-1:0]   vc_reg;
    logic [SW-1:0]       i_reg, i_next;
    logic [HW-1:0]       cur_reg, cur_next;
    logic [HW-1:0]       aux_reg, aux_next;
    logic [SW-1:0]       clr_reg, clr_next;
    logic                clr_resp_reg, clr_resp_next;
    status_t             res_st_reg, res_st_next;
    logic [HW-1:0]       res_ent_reg, res_ent_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_st_reg, m_st_next;
    logic [HW-1:0]       m_ent_reg, m_ent_next;

    logic                heap_we, slot_we;
    logic [SW-1:0]       heap_waddr, heap_raddr, slot_waddr, slot_raddr;
    logic [HW-1:0]       heap_wdata, heap_rdata;
    logic [SW-1:0]       slot_wdata, slot_rdata;

    cmd_t                cmd;
    logic [XW-1:0]       v_ext, pv_ext;
    logic                v_ok;
    logic [CW-1:0]       vc_lim, rst_lim, last;
    logic [CW:0]         l_idx, r_idx;
    logic [DIST_W-1:0]   cur_d;
    logic [HW-1:0]       best_ent;
    logic [SW-1:0]       best_idx;
    logic                best_move;

    imhdk_ram #(.WIDTH(HW), .DEPTH(MAX_VERTICES)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    imhdk_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign cmd     = cmd_t'(s_tuser);
    assign v_ext   = XW'(s_tdata[VTX_W-1:0]);
    assign v_ok    = 32'(s_tdata[VTX_W-1:0]) < 32'(MAX_VERTICES);
    assign vc_lim  = (32'(vc_reg) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_reg);
    assign rst_lim = (32'(VCNT_RESET) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                          : CW'(VCNT_RESET);
    assign last    = cnt_reg - CW'(1);
    assign l_idx   = {CW'(i_reg), 1'b1};
    assign r_idx   = l_idx + (CW+1)'(1);
    assign cur_d   = cur_reg[DIST_W-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_st_reg;
    assign pv_ext   = XW'(m_ent_reg[HW-1:DIST_W]);
    assign m_tdata  = {7'd0, m_ent_reg[DIST_W-1:0], pv_ext[VTX_W-1:0]};

    // Smaller child against the carried entry; left wins ties.
    always_comb begin
        best_ent  = cur_reg;
        best_idx  = i_reg;
        best_move = 1'b0;
        if (aux_reg[DIST_W-1:0] < cur_d) begin
            best_ent  = aux_reg;
            best_idx  = l_idx[SW-1:0];
            best_move = 1'b1;
        end
        if (state_reg == S_DN_R && heap_rdata[DIST_W-1:0] < best_ent[DIST_W-1:0]) begin
            best_ent  = heap_rdata;
            best_idx  = r_idx[SW-1:0];
            best_move = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        cur_next      = cur_reg;
        aux_next      = aux_reg;
        clr_next      = clr_reg;
        clr_resp_next = clr_resp_reg;
        res_st_next   = res_st_reg;
        res_ent_next  = res_ent_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_st_next     = m_st_reg;
        m_ent_next    = m_ent_reg;
        heap_we       = 1'b0;
        heap_waddr    = i_reg;
        heap_wdata    = cur_reg;
        heap_raddr    = '0;
        slot_we       = 1'b0;
        slot_waddr    = cur_reg[HW-1:DIST_W];
        slot_wdata    = i_reg;
        slot_raddr    = v_ext[SW-1:0];

        unique case (state_reg)
            S_CLEAR: begin
                heap_we    = 1'b1;
                heap_waddr = clr_reg;
                heap_wdata = {clr_reg, INF_DIST};
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = clr_reg;
                clr_next   = clr_reg + SW'(1);
                if (clr_reg == LAST_SLOT) begin
                    clr_next     = '0;
                    cnt_next     = clr_resp_reg ? vc_lim : rst_lim;
                    res_st_next  = ST_NOP;
                    res_ent_next = '0;
                    state_next   = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                res_ent_next = '0;
                res_st_next  = ST_NOP;
                if (s_tvalid) begin
                    unique case (cmd)
                        CMD_UPDATE: begin
                            cur_next   = {v_ext[SW-1:0], s_tdata[VTX_W +: DIST_W]};
                            state_next = v_ok ? S_UPD_SLOT : S_RESP;
                        end
                        CMD_POP: begin
                            heap_raddr = '0;
                            if (cnt_reg == '0) begin
                                res_st_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_POP_ROOT;
                            end
                        end
                        CMD_RESTART: begin
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_UPD_SLOT: begin
                i_next     = slot_rdata;
                state_next = (CW'(slot_rdata) < cnt_reg) ? S_UP_RD : S_RESP;
            end
            S_UP_RD: begin
                heap_raddr = (i_reg - SW'(1)) >> 1;
                if (i_reg == '0) begin
                    heap_we     = 1'b1;
                    slot_we     = 1'b1;
                    res_st_next = ST_UPDATED;
                    state_next  = S_RESP;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (cur_d < heap_rdata[DIST_W-1:0]) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    slot_we    = 1'b1;
                    slot_waddr = heap_rdata[HW-1:DIST_W];
                    i_next     = (i_reg - SW'(1)) >> 1;
                    state_next = S_UP_RD;
                end else begin
                    heap_we     = 1'b1;
                    slot_we     = 1'b1;
                    res_st_next = ST_UPDATED;
                    state_next  = S_RESP;
                end
            end
            S_POP_ROOT: begin
                aux_next   = heap_rdata;
                heap_raddr = last[SW-1:0];
                state_next = S_POP_LAST;
            end
            S_POP_LAST: begin
                // Root parks in the old last slot, which marks its vertex as gone.
                heap_we      = 1'b1;
                heap_waddr   = last[SW-1:0];
                heap_wdata   = aux_reg;
                slot_we      = 1'b1;
                slot_waddr   = aux_reg[HW-1:DIST_W];
                slot_wdata   = last[SW-1:0];
                res_ent_next = aux_reg;
                res_st_next  = ST_POPPED;
                cur_next     = heap_rdata;
                cnt_next     = last;
                i_next       = '0;
                state_next   = S_DN_RD;
            end
            S_DN_RD: begin
                heap_raddr = l_idx[SW-1:0];
                if (l_idx < (CW+1)'(cnt_reg)) begin
                    state_next = S_DN_L;
                end else begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_DN_L: begin
                aux_next   = heap_rdata;
                heap_raddr = r_idx[SW-1:0];
                if (r_idx < (CW+1)'(cnt_reg)) begin
                    state_next = S_DN_R;
                end else if (heap_rdata[DIST_W-1:0] < cur_d) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    slot_we    = 1'b1;
                    slot_waddr = heap_rdata[HW-1:DIST_W];
                    i_next     = l_idx[SW-1:0];
                    state_next = S_DN_RD;
                end else begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_DN_R: begin
                heap_we    = 1'b1;
                heap_wdata = best_ent;
                slot_we    = 1'b1;
                slot_waddr = best_ent[HW-1:DIST_W];
                if (best_move) begin
                    i_next     = best_idx;
                    state_next = S_DN_RD;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_st_next     = res_st_reg;
                    m_ent_next    = res_ent_reg;
                    clr_resp_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            vc_reg       <= VCNT_RESET;
            clr_reg      <= '0;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_reg      <= clr_next;
            clr_resp_reg <= clr_resp_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                vc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        cur_reg     <= cur_next;
        aux_reg     <= aux_next;
        res_st_reg  <= res_st_next;
        res_ent_reg <= res_ent_next;
        m_st_reg    <= m_st_next;
        m_ent_reg   <= m_ent_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= 32'(MAX_VERTICES))
        else $error("heap count above capacity");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!heap_we && !slot_we))
        else $error("RAM write while idle");

    a_accept_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("transaction accepted without leaving idle");

endmodule

@@ sim/heap_checker.sv @@
// Checker for the indexed min-heap: predicts each result and compares it with the block's output.
`timescale 1ns / 1ps
module heap_checker
    import imhdk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending_count
);
    localparam int NV = MAX_VERTICES_DEF;

    typedef struct packed {
        status_t           status;
        logic [VTX_W-1:0]  vtx;
        logic [DIST_W-1:0] distance;
    } heap_result_t;

    logic [VTX_W-1:0]  slot_vtx [NV];
    logic [DIST_W-1:0] slot_dist[NV];
    int unsigned       vtx_slot [NV];
    int unsigned       live_count;
    logic [VCNT_W-1:0] load_count;
    heap_result_t      expected_results[$];

    function automatic void reload();
        for (int i = 0; i < NV; i++) begin
            slot_vtx[i] = i[VTX_W-1:0];
            slot_dist[i] = INF_DIST;
            vtx_slot[i] = i;
        end
        live_count = (load_count > NV) ? NV : load_count;
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [VTX_W-1:0]  tv;
        logic [DIST_W-1:0] td;
        tv = slot_vtx[a];
        td = slot_dist[a];
        slot_vtx[a] = slot_vtx[b];
        slot_dist[a] = slot_dist[b];
        slot_vtx[b] = tv;
        slot_dist[b] = td;
        vtx_slot[slot_vtx[a]] = a;
        vtx_slot[slot_vtx[b]] = b;
    endfunction

    function automatic heap_result_t predict_heap_op(cmd_t cmd, logic [VTX_W-1:0] v,
                                                     logic [DIST_W-1:0] d);
        heap_result_t      r;
        int unsigned       i, p, best, lc, rc, last;
        logic [VTX_W-1:0]  rv;
        logic [DIST_W-1:0] rd;
        r = '{ST_NOP, '0, '0};
        if (cmd == CMD_UPDATE) begin
            if (vtx_slot[v] < live_count) begin
                i = vtx_slot[v];
                slot_dist[i] = d;
                while (i > 0) begin
                    p = (i - 1) / 2;
                    if (!(slot_dist[i] < slot_dist[p])) break;
                    swap_slots(i, p);
                    i = p;
                end
                r.status = ST_UPDATED;
            end
        end else if (cmd == CMD_POP) begin
            if (live_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                last = live_count - 1;
                rv = slot_vtx[0];
                rd = slot_dist[0];
                r = '{ST_POPPED, rv, rd};
                slot_vtx[0] = slot_vtx[last];
                slot_dist[0] = slot_dist[last];
                vtx_slot[slot_vtx[0]] = 0;
                slot_vtx[last] = rv;
                slot_dist[last] = rd;
                vtx_slot[rv] = last;
                live_count = last;
                i = 0;
                forever begin
                    best = i;
                    lc = 2 * i + 1;
                    rc = 2 * i + 2;
                    if (lc < live_count && slot_dist[lc] < slot_dist[best]) best = lc;
                    if (rc < live_count && slot_dist[rc] < slot_dist[best]) best = rc;
                    if (best == i) break;
                    swap_slots(best, i);
                    i = best;
                end
            end
        end else if (cmd == CMD_RESTART) begin
            reload();
        end
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        heap_result_t exp_r;
        heap_result_t got;
        if (!aresetn) begin
            load_count = VCNT_RESET;
            reload();
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) load_count = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_heap_op(cmd_t'(s_tuser),
                    s_tdata[9:0], s_tdata[40:10]));
            if (m_tvalid && m_tready) begin
                got = '{status_t'(m_tuser), m_tdata[9:0], m_tdata[40:10]};
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r || m_tdata[47:41] !== '0) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p, got %p", exp_r, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ sim/tb.sv @@
// Top-level testbench for the indexed min-heap: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb;
    import imhdk_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [10:0] cfg_wr_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count, pending_count;
    int          idle_cycles = 0;
    bit          calm = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    indexed_min_heap_decrease_key DUT (.*);
    heap_checker u_checker (.*);

    // receiver stall bursts
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_tready <= 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 17);
            m_tready <= 0;
            repeat (hold) @(posedge aclk);
            m_tready <= 1;
        end else begin
            m_tready <= 1;
        end
    end

    // watchdog: ends the run with FAILURE if neither side transfers within the idle limit
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays high between back-to-back transactions; dropped for random gaps unless calm, and when quiescing
    task automatic send_op(cmd_t cmd, logic [9:0] v, logic [30:0] d);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, d, v};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic quiesce();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_vertex_count(logic [10:0] n);
        quiesce();
        cfg_wr_en <= 1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    function automatic logic [30:0] rand_dist();
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 15));
            1: return 31'h7FFFFFFF;
            default: return 31'($urandom());
        endcase
    endfunction

    // well-formed phase: restart, a random mix of updates and pops with some noise, then pops
    task automatic run_phase(logic [10:0] n, int ops);
        int lim;
        set_vertex_count(n);
        send_op(CMD_RESTART, 10'd0, 31'd0);
        lim = (n == 0) ? 0 : ((n > 1024) ? 1023 : n - 1);
        for (int k = 0; k < ops; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_op(CMD_UPDATE, 10'($urandom_range(0, lim)), rand_dist());
                5, 6, 7: send_op(CMD_POP, 10'($urandom()), 31'($urandom()));
                8: send_op(CMD_UPDATE, 10'($urandom()), rand_dist());
                default: send_op(cmd_t'(2'd3), 10'($urandom()), 31'($urandom()));
            endcase
        end
        for (int k = 0; k <= lim + 1 && k < 12; k++) send_op(CMD_POP, 10'd0, 31'd0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        while (!s_tready) @(posedge aclk);
        // directed, reset count 1024
        send_op(CMD_UPDATE, 10'd1023, 31'd0);
        send_op(CMD_UPDATE, 10'd0, 31'd0);
        send_op(CMD_UPDATE, 10'd512, 31'h7FFFFFFF);
        send_op(CMD_UPDATE, 10'd5, 31'd100);
        send_op(CMD_UPDATE, 10'd5, 31'd200);
        send_op(CMD_UPDATE, 10'd6, 31'd100);
        send_op(CMD_POP, 10'h3FF, 31'h7FFFFFFF);
        send_op(CMD_POP, 10'd0, 31'd0);
        send_op(CMD_UPDATE, 10'd1023, 31'd3);
        send_op(cmd_t'(2'd3), 10'h2AA, 31'h2AAAAAAA);
        send_op(CMD_POP, 10'd0, 31'd0);
        set_vertex_count(11'd0);
        send_op(CMD_RESTART, 10'd0, 31'd0);
        send_op(CMD_POP, 10'd0, 31'd0);
        send_op(CMD_UPDATE, 10'd0, 31'd1);
        set_vertex_count(11'd1);
        send_op(CMD_RESTART, 10'd0, 31'd0);
        send_op(CMD_UPDATE, 10'd0, 31'd7);
        send_op(CMD_POP, 10'd0, 31'd0);
        send_op(CMD_POP, 10'd0, 31'd0);
        set_vertex_count(11'd2047);
        send_op(CMD_RESTART, 10'd0, 31'd0);
        send_op(CMD_UPDATE, 10'd1023, 31'h155);
        send_op(CMD_POP, 10'd0, 31'd0);
        // random phases
        run_phase(11'd7, 60);
        run_phase(11'd1, 20);
        run_phase(11'd16, 80);
        run_phase(11'd1024, 80);
        run_phase(11'd3, 40);
        run_phase(11'd2047, 40);
        run_phase(11'd30, 80);
        calm = 1;
        run_phase(11'd12, 60);
        quiesce();
        if (fail_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
